FILE: src/umab_pkg.sv
// shared types, codes and the sequencer program of the uart memory access bridge
`default_nettype none
package umab_pkg;

  localparam int HDR_BYTES = 12;
  localparam logic [3:0] HDR_LAST = 4'd11;

  localparam logic [7:0] FLAG_INC = 8'h01;
  localparam logic [7:0] FLAG_REQ = 8'h02;

  localparam logic [7:0] CMD_READ  = 8'h00;
  localparam logic [7:0] CMD_WRITE = 8'h01;

  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_READ    = 2'd1;
  localparam logic [1:0] PH_WRITE   = 2'd2;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [31:0] read_word;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] bus_address;
    logic [31:0] bus_write_data;
    logic        last;
  } result_t;

  // result source of a step
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_ECHO  = 3'd1;
  localparam logic [2:0] E_RBYTE = 3'd2;
  localparam logic [2:0] E_RREQ  = 3'd3;
  localparam logic [2:0] E_WREQ  = 3'd4;

  // datapath action of a step
  localparam logic [2:0] A_NONE    = 3'd0;
  localparam logic [2:0] A_PH_CLR  = 3'd1;
  localparam logic [2:0] A_STORE   = 3'd2;
  localparam logic [2:0] A_IDX_CLR = 3'd3;
  localparam logic [2:0] A_IDX_INC = 3'd4;
  localparam logic [2:0] A_LOAD    = 3'd5;
  localparam logic [2:0] A_STEP    = 3'd6;
  localparam logic [2:0] A_ASM     = 3'd7;

  // jump conditions, evaluated on the state before the step's action
  localparam logic [3:0] C_NEVER     = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_PH_READ   = 4'd2;
  localparam logic [3:0] C_PH_WRITE  = 4'd3;
  localparam logic [3:0] C_OP_ONE    = 4'd4;
  localparam logic [3:0] C_OP_ZERO   = 4'd5;
  localparam logic [3:0] C_HDR_OPEN  = 4'd6;
  localparam logic [3:0] C_BAD_CMD   = 4'd7;
  localparam logic [3:0] C_IDX_MORE  = 4'd8;
  localparam logic [3:0] C_IDX_LT3   = 4'd9;
  localparam logic [3:0] C_CNT_BAD   = 4'd10;
  localparam logic [3:0] C_CMD_WR    = 4'd11;
  localparam logic [3:0] C_LAST_WORD = 4'd12;
  localparam logic [3:0] C_BIW_LT3   = 4'd13;

  // program addresses
  localparam logic [4:0] UA_DISP_R = 5'd0;
  localparam logic [4:0] UA_DISP_W = 5'd1;
  localparam logic [4:0] UA_C_OP   = 5'd2;
  localparam logic [4:0] UA_C_ST   = 5'd3;
  localparam logic [4:0] UA_C_CMD  = 5'd4;
  localparam logic [4:0] UA_C_ECHO = 5'd5;
  localparam logic [4:0] UA_C_CNT  = 5'd6;
  localparam logic [4:0] UA_C_LOAD = 5'd7;
  localparam logic [4:0] UA_C_RREQ = 5'd8;
  localparam logic [4:0] UA_R_OP   = 5'd9;
  localparam logic [4:0] UA_R_BYTE = 5'd10;
  localparam logic [4:0] UA_R_STEP = 5'd11;
  localparam logic [4:0] UA_R_REQ  = 5'd12;
  localparam logic [4:0] UA_W_OP   = 5'd13;
  localparam logic [4:0] UA_W_BIW  = 5'd14;
  localparam logic [4:0] UA_W_REQ  = 5'd15;
  localparam logic [4:0] UA_W_ASM  = 5'd16;
  localparam logic [4:0] UA_END    = 5'd31;

  typedef struct packed {
    logic [2:0] emit;
    logic [2:0] act;
    logic [3:0] cond;
    logic [4:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [4:0] addr);
    ucode_t w;
    unique case (addr)
      UA_DISP_R: w = '{E_NONE,  A_NONE,    C_PH_READ,   UA_R_OP};
      UA_DISP_W: w = '{E_NONE,  A_NONE,    C_PH_WRITE,  UA_W_OP};
      UA_C_OP:   w = '{E_NONE,  A_PH_CLR,  C_OP_ONE,    UA_END};
      UA_C_ST:   w = '{E_NONE,  A_STORE,   C_HDR_OPEN,  UA_END};
      UA_C_CMD:  w = '{E_NONE,  A_IDX_CLR, C_BAD_CMD,   UA_END};
      UA_C_ECHO: w = '{E_ECHO,  A_IDX_INC, C_IDX_MORE,  UA_C_ECHO};
      UA_C_CNT:  w = '{E_NONE,  A_NONE,    C_CNT_BAD,   UA_END};
      UA_C_LOAD: w = '{E_NONE,  A_LOAD,    C_CMD_WR,    UA_END};
      UA_C_RREQ: w = '{E_RREQ,  A_NONE,    C_ALWAYS,    UA_END};
      UA_R_OP:   w = '{E_NONE,  A_IDX_CLR, C_OP_ZERO,   UA_END};
      UA_R_BYTE: w = '{E_RBYTE, A_IDX_INC, C_IDX_LT3,   UA_R_BYTE};
      UA_R_STEP: w = '{E_NONE,  A_STEP,    C_LAST_WORD, UA_END};
      UA_R_REQ:  w = '{E_RREQ,  A_NONE,    C_ALWAYS,    UA_END};
      UA_W_OP:   w = '{E_NONE,  A_NONE,    C_OP_ONE,    UA_END};
      UA_W_BIW:  w = '{E_NONE,  A_NONE,    C_BIW_LT3,   UA_W_ASM};
      UA_W_REQ:  w = '{E_WREQ,  A_STEP,    C_ALWAYS,    UA_END};
      UA_W_ASM:  w = '{E_NONE,  A_ASM,     C_ALWAYS,    UA_END};
      default:   w = '{E_NONE,  A_NONE,    C_ALWAYS,    UA_END};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/uart_memory_access_bridge_top.sv
// uart memory access bridge: header parser, echo and bus request sequencer
// The bridge takes one beat at a time on the item channel (a received serial
// byte or a returned bus read word) and answers with zero or more beats on the
// result channel (transmit bytes, bus read requests, bus write requests), the
// final one of each group flagged with last. A small microprogram in a
// read-only table runs the work, one step per clock unless an emitting step
// waits on a stalled output register; each step carries one datapath action,
// at most one result beat and a conditional jump. On the last header byte of
// a valid command the program echoes the twelve header bytes, read one per
// step from the header store, then checks the count, loads the address and
// count and, for a read, sends the first read request. A single result
// register holds the output; a new item is taken once the program for the
// previous one has ended, even while its final result still waits in the
// output register.
`default_nettype none
module uart_memory_access_bridge_top #(
  parameter int MAX_WORDS = 128
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire umab_pkg::item_t item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output umab_pkg::result_t    result
);

  // words_remaining never exceeds MAX_WORDS - 1
  localparam int RW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  // sequencer control
  logic                 busy;
  logic [4:0]           upc;
  umab_pkg::item_t      cur;
  umab_pkg::ucode_t     uw;

  // datapath state
  logic [7:0]           header_store [umab_pkg::HDR_BYTES];
  logic [3:0]           header_count;
  logic [1:0]           phase;
  logic [RW-1:0]        words_remaining;
  logic [31:0]          current_address;
  logic [23:0]          assembly_word;
  logic [1:0]           byte_in_word;
  logic [3:0]           idx;

  logic                 emit_ok;
  logic                 step_go;
  logic                 cond_true;
  logic [3:0]           cnt_eff;
  logic [31:0]          cnt_word;
  logic                 cnt_ok;
  logic [7:0]           cmd;
  logic [7:0]           echo_byte;
  logic [7:0]           rd_byte;
  umab_pkg::result_t    result_next;

  assign item_stall = busy;
  assign uw         = umab_pkg::ucode_rom(upc);

  // the output register may be loaded when empty or being drained this cycle
  assign emit_ok = !result_valid || !result_stall;
  assign step_go = busy && ((uw.emit == umab_pkg::E_NONE) || emit_ok);

  // header decode, fixed store positions
  assign cmd      = header_store[2];
  assign cnt_word = {header_store[8], header_store[9], header_store[10], header_store[11]};
  assign cnt_ok   = (cnt_word != 32'd0) && (cnt_word < 32'(MAX_WORDS));
  // a stale count at or above the header length restarts collection
  assign cnt_eff  = (header_count > umab_pkg::HDR_LAST) ? 4'd0 : header_count;

  // echo byte with the request flag cleared in the flags byte
  assign echo_byte = (idx == 4'd3) ? (header_store[idx] & ~umab_pkg::FLAG_REQ)
                                   : header_store[idx];

  // read word goes out most significant byte first
  always_comb begin
    unique case (idx[1:0])
      2'd0:    rd_byte = cur.read_word[31:24];
      2'd1:    rd_byte = cur.read_word[23:16];
      2'd2:    rd_byte = cur.read_word[15:8];
      default: rd_byte = cur.read_word[7:0];
    endcase
  end

  // jump condition of the current step
  always_comb begin
    unique case (uw.cond)
      umab_pkg::C_NEVER:     cond_true = 1'b0;
      umab_pkg::C_ALWAYS:    cond_true = 1'b1;
      umab_pkg::C_PH_READ:   cond_true = (phase == umab_pkg::PH_READ);
      umab_pkg::C_PH_WRITE:  cond_true = (phase == umab_pkg::PH_WRITE);
      umab_pkg::C_OP_ONE:    cond_true = cur.operation;
      umab_pkg::C_OP_ZERO:   cond_true = !cur.operation;
      umab_pkg::C_HDR_OPEN:  cond_true = (cnt_eff != umab_pkg::HDR_LAST);
      umab_pkg::C_BAD_CMD:   cond_true = (cmd != umab_pkg::CMD_READ) &&
                                         (cmd != umab_pkg::CMD_WRITE);
      umab_pkg::C_IDX_MORE:  cond_true = (idx != umab_pkg::HDR_LAST);
      umab_pkg::C_IDX_LT3:   cond_true = (idx != 4'd3);
      umab_pkg::C_CNT_BAD:   cond_true = !cnt_ok;
      umab_pkg::C_CMD_WR:    cond_true = (cmd == umab_pkg::CMD_WRITE);
      umab_pkg::C_LAST_WORD: cond_true = (words_remaining == RW'(1));
      umab_pkg::C_BIW_LT3:   cond_true = (byte_in_word != 2'd3);
      default:               cond_true = 1'b1;
    endcase
  end

  // result beat of the current step
  always_comb begin
    result_next                = '0;
    result_next.kind           = umab_pkg::KIND_TX;
    unique case (uw.emit)
      umab_pkg::E_ECHO: begin
        result_next.tx_byte = echo_byte;
        // last echo byte ends the group unless a read request follows
        result_next.last    = (idx == umab_pkg::HDR_LAST) &&
                              !(cnt_ok && (cmd == umab_pkg::CMD_READ));
      end
      umab_pkg::E_RBYTE: begin
        result_next.tx_byte = rd_byte;
        result_next.last    = (idx == 4'd3) && (words_remaining == RW'(1));
      end
      umab_pkg::E_RREQ: begin
        result_next.kind        = umab_pkg::KIND_READ;
        result_next.bus_address = current_address;
        result_next.last        = 1'b1;
      end
      umab_pkg::E_WREQ: begin
        result_next.kind           = umab_pkg::KIND_WRITE;
        result_next.bus_address    = current_address;
        result_next.bus_write_data = {assembly_word, cur.rx_byte};
        result_next.last           = 1'b1;
      end
      default: ;
    endcase
  end

  // step counter, output register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      upc             <= umab_pkg::UA_DISP_R;
      result_valid    <= 1'b0;
      header_count    <= 4'd0;
      phase           <= umab_pkg::PH_COLLECT;
      words_remaining <= '0;
      current_address <= 32'd0;
      assembly_word   <= 24'd0;
      byte_in_word    <= 2'd0;
    end else begin
      // output register loads on an emitting step, else drains when not stalled
      if (step_go && (uw.emit != umab_pkg::E_NONE)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (!busy) begin
        if (item_valid) begin
          busy <= 1'b1;
          upc  <= umab_pkg::UA_DISP_R;
        end
      end else if (step_go) begin
        unique case (uw.act)
          umab_pkg::A_PH_CLR: phase <= umab_pkg::PH_COLLECT;
          umab_pkg::A_STORE: begin
            header_count <= (cnt_eff == umab_pkg::HDR_LAST) ? 4'd0 : cnt_eff + 4'd1;
          end
          umab_pkg::A_LOAD: begin
            current_address <= {header_store[4], header_store[5],
                                header_store[6], header_store[7]};
            words_remaining <= cnt_word[RW-1:0];
            assembly_word   <= 24'd0;
            byte_in_word    <= 2'd0;
            phase           <= (cmd == umab_pkg::CMD_READ) ? umab_pkg::PH_READ
                                                          : umab_pkg::PH_WRITE;
          end
          umab_pkg::A_STEP: begin
            if ((header_store[3] & umab_pkg::FLAG_INC) != 8'd0) begin
              current_address <= current_address + 32'd4;
            end
            words_remaining <= words_remaining - RW'(1);
            assembly_word   <= 24'd0;
            byte_in_word    <= 2'd0;
            if (words_remaining == RW'(1)) begin
              phase <= umab_pkg::PH_COLLECT;
            end
          end
          umab_pkg::A_ASM: begin
            assembly_word <= {assembly_word[15:0], cur.rx_byte};
            byte_in_word  <= byte_in_word + 2'd1;
          end
          default: ;
        endcase

        // conditional jump, the end mark returns the sequencer to idle
        if (cond_true) begin
          if (uw.target == umab_pkg::UA_END) begin
            busy <= 1'b0;
          end else begin
            upc <= uw.target;
          end
        end else begin
          upc <= upc + 5'd1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (!busy && item_valid) begin
      cur <= item;
    end
    if (step_go && (uw.emit != umab_pkg::E_NONE)) begin
      result <= result_next;
    end
    if (step_go && (uw.act == umab_pkg::A_STORE)) begin
      header_store[cnt_eff] <= cur.rx_byte;
    end
    if (step_go && (uw.act == umab_pkg::A_IDX_CLR)) begin
      idx <= 4'd0;
    end else if (step_go && (uw.act == umab_pkg::A_IDX_INC)) begin
      idx <= idx + 4'd1;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_uart_memory_access_bridge_top.sv
// self-checking testbench of the uart memory access bridge: header, echo, read and write traffic
`timescale 1ns / 1ps
module tb_uart_memory_access_bridge_top;

  localparam int CLK_PERIOD = 20;
  localparam int BRIDGE_MAX_WORDS = 128;
  localparam int ITEM_TARGET = 210;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // receiver stall patterns
  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_LIGHT  = 2'd1;
  localparam logic [1:0] STALL_HEAVY  = 2'd2;
  localparam logic [1:0] STALL_TOGGLE = 2'd3;

  // kinds of random transaction
  localparam int TXN_READ       = 0;
  localparam int TXN_WRITE      = 1;
  localparam int TXN_BAD_CMD    = 2;
  localparam int TXN_ZERO_COUNT = 3;
  localparam int TXN_BIG_COUNT  = 4;
  localparam int TXN_NOISE      = 5;
  localparam int TXN_KINDS      = 6;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  umab_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  umab_pkg::result_t result;

  // beats waiting to go out on the item channel, filled by the stimulus process
  umab_pkg::item_t   stim_items[$];
  // result beats the bridge owes, oldest first
  umab_pkg::result_t reply_beats[$];
  int      error_count = 0;
  int      useful_items = 0;

  // shadow of the bridge state, advanced at every accepted item beat
  logic [7:0]  hdr [umab_pkg::HDR_BYTES];
  int          hdr_cnt = 0;
  logic [1:0]  ph = umab_pkg::PH_COLLECT;
  logic [6:0]  words_left = '0;
  logic [31:0] cur_addr = '0;
  logic [23:0] asm_word = '0;
  logic [1:0]  biw = '0;

  // pressure control: the stimulus arms it, the receiver runs it once
  logic hold_off_armed = 1'b0;
  logic hold_off_done = 1'b0;

  uart_memory_access_bridge_top #(
    .MAX_WORDS(BRIDGE_MAX_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic umab_pkg::result_t make_beat(input logic [1:0] kind,
                                                  input logic [7:0] txb,
                                                  input logic [31:0] addr,
                                                  input logic [31:0] wdata);
    umab_pkg::result_t r;
    r.kind = kind;
    r.tx_byte = txb;
    r.bus_address = addr;
    r.bus_write_data = wdata;
    r.last = 1'b0;
    return r;
  endfunction

  // works out the result beats of one accepted item and moves the shadow state on
  task automatic bridge_predict(input umab_pkg::item_t it);
    umab_pkg::result_t beats[$];
    logic [31:0]       cnt;
    logic [7:0]        echo_byte;
    case (ph)
      umab_pkg::PH_READ: begin
        // a returned word goes out msb first, then the next read request if any
        if (it.operation) begin
          for (int i = 0; i < 4; i++)
            beats.push_back(make_beat(umab_pkg::KIND_TX,
                                      8'(it.read_word >> (24 - 8 * i)), '0, '0));
          if (hdr[3] & umab_pkg::FLAG_INC) cur_addr = cur_addr + 32'd4;
          words_left = words_left - 7'd1;
          if (words_left != 0)
            beats.push_back(make_beat(umab_pkg::KIND_READ, '0, cur_addr, '0));
          else ph = umab_pkg::PH_COLLECT;
        end
      end
      umab_pkg::PH_WRITE: begin
        // four serial bytes make one big-endian write word
        if (!it.operation) begin
          if (biw < 2'd3) begin
            asm_word = {asm_word[15:0], it.rx_byte};
            biw = biw + 2'd1;
          end else begin
            beats.push_back(make_beat(umab_pkg::KIND_WRITE, '0, cur_addr,
                                      {asm_word, it.rx_byte}));
            asm_word = '0;
            biw = '0;
            if (hdr[3] & umab_pkg::FLAG_INC) cur_addr = cur_addr + 32'd4;
            words_left = words_left - 7'd1;
            if (words_left == 0) ph = umab_pkg::PH_COLLECT;
          end
        end
      end
      default: begin
        ph = umab_pkg::PH_COLLECT;
        if (!it.operation) begin
          hdr[hdr_cnt] = it.rx_byte;
          hdr_cnt++;
          if (hdr_cnt == umab_pkg::HDR_BYTES) begin
            hdr_cnt = 0;
            if (hdr[2] == umab_pkg::CMD_READ || hdr[2] == umab_pkg::CMD_WRITE) begin
              // echo with the request flag cleared
              for (int i = 0; i < umab_pkg::HDR_BYTES; i++) begin
                echo_byte = (i == 3) ? (hdr[i] & ~umab_pkg::FLAG_REQ) : hdr[i];
                beats.push_back(make_beat(umab_pkg::KIND_TX, echo_byte, '0, '0));
              end
              cnt = {hdr[8], hdr[9], hdr[10], hdr[11]};
              if (cnt != 0 && cnt < BRIDGE_MAX_WORDS) begin
                cur_addr = {hdr[4], hdr[5], hdr[6], hdr[7]};
                words_left = cnt[6:0];
                asm_word = '0;
                biw = '0;
                if (hdr[2] == umab_pkg::CMD_READ) begin
                  ph = umab_pkg::PH_READ;
                  beats.push_back(make_beat(umab_pkg::KIND_READ, '0, cur_addr, '0));
                end else begin
                  ph = umab_pkg::PH_WRITE;
                end
              end
            end
          end
        end
      end
    endcase
    if (beats.size() != 0) beats[$].last = 1'b1;
    foreach (beats[i]) reply_beats.push_back(beats[i]);
  endtask

  task automatic check_beat(input umab_pkg::result_t got);
    umab_pkg::result_t want;
    if (reply_beats.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("unexpected result beat: kind %0d tx %02h addr %08h data %08h last %0b",
                 got.kind, got.tx_byte, got.bus_address, got.bus_write_data, got.last);
    end else begin
      want = reply_beats.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
          got.bus_address !== want.bus_address ||
          got.bus_write_data !== want.bus_write_data || got.last !== want.last) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("result beat mismatch at %0t", $realtime);
          $display("  expected kind %0d tx %02h addr %08h data %08h last %0b",
                   want.kind, want.tx_byte, want.bus_address, want.bus_write_data, want.last);
          $display("  actual   kind %0d tx %02h addr %08h data %08h last %0b",
                   got.kind, got.tx_byte, got.bus_address, got.bus_write_data, got.last);
        end
      end
    end
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) bridge_predict(item);
      // a stalled beat holds; otherwise the slot is free for the next one
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (stim_items.size() != 0) begin
          item_valid <= 1'b1;
          item <= stim_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            // often back to back, more often short gaps, now and then a long one
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes at random, plus one long hold-off
  logic [1:0] stall_mode = STALL_NONE;
  int         mode_left = 0;
  int         hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_beat(result);
      if (hold_off_armed && !hold_off_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = 2'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  result_stall <= 1'b0;
          STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
          default:     result_stall <= ~result_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_item(input logic op, input logic [7:0] b, input logic [31:0] w,
                            input bit counts);
    umab_pkg::item_t it;
    it.operation = op;
    it.rx_byte = b;
    it.read_word = w;
    stim_items.push_back(it);
    if (counts) useful_items++;
  endtask

  // serial header: random id, tag and flags around the given command, address and count
  task automatic queue_header(input logic [7:0] cmd, input logic [31:0] addr,
                              input logic [31:0] count);
    logic [7:0] h [umab_pkg::HDR_BYTES];
    h[0] = 8'($urandom());
    h[1] = 8'($urandom());
    h[2] = cmd;
    h[3] = 8'($urandom());
    {h[4], h[5], h[6], h[7]} = addr;
    {h[8], h[9], h[10], h[11]} = count;
    foreach (h[i]) queue_item(1'b0, h[i], $urandom(), 1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (stim_items.size() != 0 || item_valid);
  endtask

  // brings the bridge back to an empty header, finishing any open data phase
  task automatic resync();
    while (!(ph == umab_pkg::PH_COLLECT && hdr_cnt == 0)) begin
      if (ph == umab_pkg::PH_READ) begin
        repeat (int'(words_left)) queue_item(1'b1, 8'($urandom()), $urandom(), 1'b1);
      end else if (ph == umab_pkg::PH_WRITE) begin
        repeat (int'(words_left) * 4 - int'(biw))
          queue_item(1'b0, 8'($urandom()), $urandom(), 1'b1);
      end else begin
        // fill the header with a bad command or a huge count where still open
        for (int p = hdr_cnt; p < umab_pkg::HDR_BYTES; p++)
          queue_item(1'b0, (p == 2) ? 8'hA5 : (p >= 8) ? 8'hFF : 8'($urandom()),
                     $urandom(), 1'b1);
      end
      wait_drained();
    end
  endtask

  function automatic logic [31:0] pick_address();
    // now and then right below the top so that the increment wraps
    return ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 | ($urandom() & 32'hC) : $urandom();
  endfunction

  function automatic int pick_words();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
  endfunction

  initial begin
    int txn;
    int kind;
    int n;
    int guard;
    logic [31:0] count;

    // directed: read data with nothing open is dropped
    queue_item(1'b1, 8'h00, 32'hFFFF_FFFF, 1'b1);
    // read of two words at the top of the address space, all flags set
    queue_item(1'b0, 8'h00, 32'h0000_0000, 1'b1);
    queue_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    queue_item(1'b0, umab_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1);
    queue_item(1'b0, 8'hFF, 32'h0000_0000, 1'b1);
    for (int i = 0; i < 4; i++) queue_item(1'b0, 8'hFF, 32'h0, 1'b1);
    queue_item(1'b0, 8'h00, 32'h0, 1'b1);
    queue_item(1'b0, 8'h00, 32'h0, 1'b1);
    queue_item(1'b0, 8'h00, 32'h0, 1'b1);
    queue_item(1'b0, 8'h02, 32'h0, 1'b1);
    // a serial byte in the read phase is dropped
    queue_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_item(1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    queue_item(1'b1, 8'h00, 32'h0000_0000, 1'b1);
    wait_drained();
    resync();

    txn = 0;
    while (useful_items < ITEM_TARGET) begin
      if (txn == 3) begin
        // long receiver hold-off under a long read so that the bridge backs up
        hold_off_armed = 1'b1;
        queue_header(umab_pkg::CMD_READ, pick_address(), 32'd24);
        repeat (24) queue_item(1'b1, 8'($urandom()), $urandom(), 1'b1);
      end else begin
        if (txn < TXN_KINDS + 3) begin
          kind = txn % TXN_KINDS;
        end else begin
          n = $urandom_range(0, 9);
          kind = (n < 4) ? TXN_READ : (n < 7) ? TXN_WRITE : (n == 7) ? TXN_BAD_CMD :
                 (n == 8) ? ($urandom_range(0, 1) ? TXN_ZERO_COUNT : TXN_BIG_COUNT) :
                 TXN_NOISE;
        end
        case (kind)
          TXN_READ: begin
            n = pick_words();
            queue_header(umab_pkg::CMD_READ, pick_address(), n);
            repeat (n) begin
              if ($urandom_range(0, 5) == 0)
                queue_item(1'b0, 8'($urandom()), $urandom(), 1'b0);
              queue_item(1'b1, 8'($urandom()), $urandom(), 1'b1);
            end
          end
          TXN_WRITE: begin
            n = pick_words();
            queue_header(umab_pkg::CMD_WRITE, pick_address(), n);
            repeat (n * 4) begin
              if ($urandom_range(0, 3) == 0)
                queue_item(1'b1, 8'($urandom()), $urandom(), 1'b0);
              queue_item(1'b0, 8'($urandom()), $urandom(), 1'b1);
            end
          end
          TXN_BAD_CMD: begin
            queue_header(8'($urandom_range(2, 255)), $urandom(), $urandom_range(0, 8));
          end
          TXN_ZERO_COUNT: begin
            queue_header($urandom_range(0, 1) ? umab_pkg::CMD_WRITE : umab_pkg::CMD_READ,
                         $urandom(), 32'd0);
          end
          TXN_BIG_COUNT: begin
            case ($urandom_range(0, 2))
              0:       count = BRIDGE_MAX_WORDS;
              1:       count = 32'hFFFF_FFFF;
              default: count = $urandom() | 32'h0000_0100;
            endcase
            queue_header($urandom_range(0, 1) ? umab_pkg::CMD_WRITE : umab_pkg::CMD_READ,
                         $urandom(), count);
          end
          default: begin
            // broken header: a few stray bytes and read words, completed by resync
            repeat ($urandom_range(1, 11)) begin
              if ($urandom_range(0, 2) == 0) queue_item(1'b1, 8'($urandom()), $urandom(), 1'b0);
              else queue_item(1'b0, 8'($urandom()), $urandom(), 1'b1);
            end
          end
        endcase
      end
      wait_drained();
      resync();
      txn++;
    end

    // drain the result channel, then keep waiting to catch stray beats
    guard = 0;
    while (reply_beats.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
    if (reply_beats.size() != 0) begin
      error_count += reply_beats.size();
      $display("%0d result beats never arrived", reply_beats.size());
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #(CLK_PERIOD * 400_000);
    $display("timeout with %0d result beats outstanding", reply_beats.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
src/umab_pkg.sv
src/uart_memory_access_bridge_top.sv
tb/sv/tb_uart_memory_access_bridge_top.sv
